// ===== rtl/crcf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// crcf_pkg
// shared types and codes for the central register and channel file
// ----------------------------------------------------------------------------
package crcf_pkg;

  // access codes carried by an item
  typedef enum logic [2:0] {
    FUNC_RD_CENTRAL = 3'd0,
    FUNC_WR_CENTRAL = 3'd1,
    FUNC_WR_G       = 3'd2,
    FUNC_RD_CHANNEL = 3'd3,
    FUNC_WR_CHANNEL = 3'd4
  } func_t;

  // central register addresses
  localparam logic [11:0] ADDR_A    = 12'o0;
  localparam logic [11:0] ADDR_L    = 12'o1;
  localparam logic [11:0] ADDR_Q    = 12'o2;
  localparam logic [11:0] ADDR_EB   = 12'o3;
  localparam logic [11:0] ADDR_FB   = 12'o4;
  localparam logic [11:0] ADDR_Z    = 12'o5;
  localparam logic [11:0] ADDR_BB   = 12'o6;
  localparam logic [11:0] ADDR_CYR  = 12'o20;
  localparam logic [11:0] ADDR_SR   = 12'o21;
  localparam logic [11:0] ADDR_CYL  = 12'o22;
  localparam logic [11:0] ADDR_EDOP = 12'o23;

  // i/o channel numbers (low six bits of addr)
  localparam logic [5:0] CH_L        = 6'o01;
  localparam logic [5:0] CH_Q        = 6'o02;
  localparam logic [5:0] CH_HISCALER = 6'o03;
  localparam logic [5:0] CH_LOSCALER = 6'o04;
  localparam logic [5:0] CH_BYTE0    = 6'o05;
  localparam logic [5:0] CH_BYTE1    = 6'o06;
  localparam logic [5:0] CH_SUPERBNK = 6'o07;
  localparam logic [5:0] CH_OUT10    = 6'o10;
  localparam logic [5:0] CH_DSPLAMP  = 6'o11;
  localparam logic [5:0] CH_OUT12    = 6'o12;
  localparam logic [5:0] CH_ALMTEST  = 6'o13;
  localparam logic [5:0] CH_OUT14    = 6'o14;
  localparam logic [5:0] CH_KEY_A    = 6'o15;
  localparam logic [5:0] CH_KEY_B    = 6'o16;
  localparam logic [5:0] CH_SPARE30  = 6'o30;
  localparam logic [5:0] CH_SPARE31  = 6'o31;
  localparam logic [5:0] CH_SPARE32  = 6'o32;
  localparam logic [5:0] CH_SPARE33  = 6'o33;

  // armed editing of later G writes, kept until another edit address is read
  typedef enum logic [2:0] {
    EDIT_NONE,
    EDIT_CYR,
    EDIT_SR,
    EDIT_CYL,
    EDIT_EDOP
  } edit_t;

  typedef struct packed {
    logic        opr_error;
    logic        vn_flash;
    logic        key_rel;
    logic        temp;
    logic        uplink;
    logic        cpu_active;
    logic        restart_flag;
    logic        restart_lamp;
    logic        standby_lamp;
  } lamp_t;

  localparam lamp_t LAMP_RESET = '{
    opr_error:    1'b0,
    vn_flash:     1'b0,
    key_rel:      1'b0,
    temp:         1'b0,
    uplink:       1'b0,
    cpu_active:   1'b0,
    restart_flag: 1'b1,
    restart_lamp: 1'b1,
    standby_lamp: 1'b0
  };

  typedef struct packed {
    logic [2:0]  func;
    logic [11:0] addr;
    logic [15:0] wdata;
    logic [30:0] scaler_count;
    logic        flash_on;
    logic        standby_on;
    logic [15:0] key_channel_a;
    logic [15:0] key_channel_b;
  } in_item_t;

  typedef struct packed {
    logic [15:0] rdata;
    logic [15:0] g_value;
    logic        opr_error_lamp;
    logic        vn_flash_lamp;
    logic        key_rel_lamp;
    logic        temp_lamp;
    logic        uplink_lamp;
    logic        cpu_active_lamp;
    logic        restart_flag;
    logic        restart_lamp;
    logic        standby_lamp;
  } out_item_t;

endpackage
`default_nettype wire

// ===== rtl/central_register_and_channel_file.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// central_register_and_channel_file
// central registers, G edit network and i/o channels of a 16-bit machine
// ----------------------------------------------------------------------------
// Each item is one access (read or write of a central register, an edited
// write of G, or a read or write of an i/o channel) and gives exactly one
// result item carrying the read word, the G register after the access and
// the display lamp state. Items are taken one per clock while out_ready does
// not hold a waiting result: an item is held in the input register, the
// access logic runs between that register and the result register, and the
// result is registered in the result register until it is taken. While a
// result waits on out_ready the input register still takes one more item;
// after that in_ready stays low until the waiting result is taken.
// Register state is updated in the cycle the item passes from input to
// result register, so each item sees everything earlier items left behind.
// ----------------------------------------------------------------------------
module central_register_and_channel_file (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire crcf_pkg::in_item_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output crcf_pkg::out_item_t      out_data
);

  // input register
  logic                in_valid_r;
  crcf_pkg::in_item_t  in_item_r;

  // result register
  logic                out_valid_r;
  crcf_pkg::out_item_t out_item_r, out_item_nxt;

  logic                advance;
  logic [15:0]         rdata;
  logic [15:0]         g_value;
  crcf_pkg::lamp_t     lamps;

  // item moves to the result side when that register is free or draining
  assign advance  = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_valid_r <= 1'b1;
    end else if (advance) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_item_r <= in_data;
    end
  end

  // register, channel and lamp state
  crcf_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (advance),
    .item  (in_item_r),
    .rdata (rdata),
    .lamps (lamps)
  );

  // G register and edit network
  crcf_gate u_gate (
    .clk     (clk),
    .rst_n   (rst_n),
    .fire    (advance),
    .item    (in_item_r),
    .g_value (g_value)
  );

  always_comb begin
    out_item_nxt.rdata           = rdata;
    out_item_nxt.g_value         = g_value;
    out_item_nxt.opr_error_lamp  = lamps.opr_error;
    out_item_nxt.vn_flash_lamp   = lamps.vn_flash;
    out_item_nxt.key_rel_lamp    = lamps.key_rel;
    out_item_nxt.temp_lamp       = lamps.temp;
    out_item_nxt.uplink_lamp     = lamps.uplink;
    out_item_nxt.cpu_active_lamp = lamps.cpu_active;
    out_item_nxt.restart_flag    = lamps.restart_flag;
    out_item_nxt.restart_lamp    = lamps.restart_lamp;
    out_item_nxt.standby_lamp    = lamps.standby_lamp;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_item_r <= out_item_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

`ifndef SYNTHESIS
  // a held item is neither dropped nor altered
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && !advance |=> in_valid_r && $stable(in_item_r))
    else $error("held input item lost or changed");

  // every item leaving the input register shows up as a result
  assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid)
    else $error("result missing after access");

  // the restart latch is only ever cleared, and its lamp is lit while it is set
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.restart_flag |-> out_data.restart_lamp)
    else $error("restart latch set with lamp dark");

  // write accesses return a zero read word
  assert property (@(posedge clk) disable iff (!rst_n)
    advance && (in_item_r.func == crcf_pkg::FUNC_WR_CENTRAL ||
                in_item_r.func == crcf_pkg::FUNC_WR_CHANNEL ||
                in_item_r.func == crcf_pkg::FUNC_WR_G)
    |=> out_data.rdata == 16'd0)
    else $error("nonzero read word on write access");
`endif

endmodule
`default_nettype wire

// ===== rtl/crcf_gate.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// crcf_gate
// G register with its edit network and the armed edit mode
// ----------------------------------------------------------------------------
module crcf_gate (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              fire,
  input  wire crcf_pkg::in_item_t item,
  output logic [15:0]            g_value
);

  crcf_pkg::edit_t edit_r, edit_nxt;
  logic [15:0]     gate_r, gate_nxt;
  logic [15:0]     wl;

  assign wl = item.wdata;

  always_comb begin
    edit_nxt = edit_r;
    gate_nxt = gate_r;
    if (fire) begin
      case (item.func)
        crcf_pkg::FUNC_RD_CENTRAL: begin
          unique case (item.addr)
            crcf_pkg::ADDR_CYR:  edit_nxt = crcf_pkg::EDIT_CYR;
            crcf_pkg::ADDR_SR:   edit_nxt = crcf_pkg::EDIT_SR;
            crcf_pkg::ADDR_CYL:  edit_nxt = crcf_pkg::EDIT_CYL;
            crcf_pkg::ADDR_EDOP: edit_nxt = crcf_pkg::EDIT_EDOP;
            default:             edit_nxt = edit_r;
          endcase
        end
        crcf_pkg::FUNC_WR_G: begin
          unique case (edit_r)
            crcf_pkg::EDIT_CYR:  gate_nxt = {wl[0], 1'b0, wl[15], wl[13:1]};
            crcf_pkg::EDIT_SR:   gate_nxt = {wl[15], 1'b0, wl[15], wl[13:1]};
            crcf_pkg::EDIT_CYL:  gate_nxt = {wl[13], 1'b0, wl[12:0], wl[15]};
            crcf_pkg::EDIT_EDOP: gate_nxt = {9'd0, wl[13:7]};
            default:             gate_nxt = wl;
          endcase
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      edit_r <= crcf_pkg::EDIT_NONE;
      gate_r <= 16'd0;
    end else begin
      edit_r <= edit_nxt;
      gate_r <= gate_nxt;
    end
  end

  // value after this access
  assign g_value = gate_nxt;

endmodule
`default_nettype wire

// ===== rtl/crcf_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// crcf_core
// central registers, i/o channels and lamp flags
// ----------------------------------------------------------------------------
module crcf_core (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              fire,
  input  wire crcf_pkg::in_item_t item,
  output logic [15:0]            rdata,
  output crcf_pkg::lamp_t        lamps
);

  logic [15:0]     acc_r, acc_nxt;
  logic [15:0]     low_r, low_nxt;
  logic [15:0]     ret_r, ret_nxt;
  logic [15:0]     pc_r, pc_nxt;
  logic [2:0]      eb_r, eb_nxt;
  logic [4:0]      fb_r, fb_nxt;
  logic [2:0]      feb_r, feb_nxt;
  logic [7:0]      byte0_r, byte0_nxt;
  logic [7:0]      byte1_r, byte1_nxt;
  logic [14:0]     out_ch_r [5];
  logic [14:0]     out_ch_nxt [5];
  logic            alarm_r, alarm_nxt;
  crcf_pkg::lamp_t lamps_r, lamps_nxt;

  logic [5:0]      ch;
  logic [15:0]     wl;
  logic [14:0]     cw;
  logic [15:0]     low_fixed;
  logic [15:0]     fb_word;
  logic [14:0]     och;

  assign ch        = item.addr[5:0];
  assign wl        = item.wdata;
  // channel word: bit 14 is dropped and bit 15 becomes its top bit
  assign cw        = {wl[15], wl[13:0]};
  assign low_fixed = {low_r[15], low_r[15], low_r[13:0]};
  assign fb_word   = {fb_r[4], fb_r, 10'd0};
  assign och       = out_ch_r[ch[2:0]];

  always_comb begin
    rdata = 16'd0;
    if (fire) begin
      case (item.func)
        crcf_pkg::FUNC_RD_CENTRAL: begin
          unique case (item.addr)
            crcf_pkg::ADDR_A:  rdata = acc_r;
            crcf_pkg::ADDR_L:  rdata = low_fixed;
            crcf_pkg::ADDR_Q:  rdata = ret_r;
            crcf_pkg::ADDR_EB: rdata = {5'd0, eb_r, 8'd0};
            crcf_pkg::ADDR_FB: rdata = fb_word;
            crcf_pkg::ADDR_Z:  rdata = pc_r;
            crcf_pkg::ADDR_BB: rdata = fb_word | {13'd0, eb_r};
            default:           rdata = 16'd0;
          endcase
        end
        crcf_pkg::FUNC_RD_CHANNEL: begin
          unique case (ch) inside
            crcf_pkg::CH_L:        rdata = low_fixed;
            crcf_pkg::CH_Q:        rdata = ret_r;
            crcf_pkg::CH_HISCALER: rdata = {2'd0, item.scaler_count[30:17]};
            crcf_pkg::CH_LOSCALER: rdata = {2'd0, item.scaler_count[16:3]};
            crcf_pkg::CH_BYTE0:    rdata = {8'd0, byte0_r};
            crcf_pkg::CH_BYTE1:    rdata = {8'd0, byte1_r};
            crcf_pkg::CH_SUPERBNK: rdata = {9'd0, feb_r, 4'd0};
            crcf_pkg::CH_OUT10, crcf_pkg::CH_DSPLAMP, crcf_pkg::CH_OUT12,
            crcf_pkg::CH_ALMTEST, crcf_pkg::CH_OUT14:
                                   rdata = {och[14], och};
            crcf_pkg::CH_KEY_A:    rdata = item.key_channel_a;
            crcf_pkg::CH_KEY_B:    rdata = item.key_channel_b;
            crcf_pkg::CH_SPARE30, crcf_pkg::CH_SPARE31, crcf_pkg::CH_SPARE32,
            crcf_pkg::CH_SPARE33:
                                   rdata = 16'hFFFF;
            default:               rdata = 16'd0;
          endcase
        end
        default: rdata = 16'd0;
      endcase
    end
  end

  always_comb begin
    acc_nxt    = acc_r;
    low_nxt    = low_r;
    ret_nxt    = ret_r;
    pc_nxt     = pc_r;
    eb_nxt     = eb_r;
    fb_nxt     = fb_r;
    feb_nxt    = feb_r;
    byte0_nxt  = byte0_r;
    byte1_nxt  = byte1_r;
    out_ch_nxt = out_ch_r;
    alarm_nxt  = alarm_r;
    lamps_nxt  = lamps_r;
    if (fire) begin
      case (item.func)
        crcf_pkg::FUNC_WR_CENTRAL: begin
          unique case (item.addr)
            crcf_pkg::ADDR_A:  acc_nxt = wl;
            crcf_pkg::ADDR_L:  low_nxt = wl;
            crcf_pkg::ADDR_Q:  ret_nxt = wl;
            crcf_pkg::ADDR_EB: eb_nxt  = wl[10:8];
            crcf_pkg::ADDR_FB: fb_nxt  = {wl[15], wl[13:10]};
            crcf_pkg::ADDR_Z:  pc_nxt  = wl;
            crcf_pkg::ADDR_BB: begin
              eb_nxt = wl[2:0];
              fb_nxt = {wl[15], wl[13:10]};
            end
            default: ;
          endcase
        end
        crcf_pkg::FUNC_WR_CHANNEL: begin
          unique case (ch)
            crcf_pkg::CH_L:        low_nxt   = wl;
            crcf_pkg::CH_Q:        ret_nxt   = wl;
            crcf_pkg::CH_BYTE0:    byte0_nxt = wl[7:0];
            crcf_pkg::CH_BYTE1:    byte1_nxt = wl[7:0];
            crcf_pkg::CH_SUPERBNK: feb_nxt   = wl[6:4];
            crcf_pkg::CH_OUT10:    out_ch_nxt[0] = cw;
            crcf_pkg::CH_DSPLAMP: begin
              out_ch_nxt[1]        = cw;
              lamps_nxt.opr_error  = !item.flash_on && cw[6];
              lamps_nxt.vn_flash   = item.flash_on && cw[5];
              lamps_nxt.key_rel    = !item.flash_on && cw[4];
              lamps_nxt.temp       = cw[3];
              lamps_nxt.uplink     = cw[2];
              lamps_nxt.cpu_active = cw[1];
              // restart clear; the lamp stays lit under alarm test
              if (cw[9]) begin
                lamps_nxt.restart_flag = 1'b0;
                if (!alarm_r) lamps_nxt.restart_lamp = 1'b0;
              end
            end
            crcf_pkg::CH_OUT12:    out_ch_nxt[2] = cw;
            crcf_pkg::CH_ALMTEST: begin
              out_ch_nxt[3]          = cw;
              alarm_nxt              = cw[9];
              lamps_nxt.restart_lamp = lamps_r.restart_flag || cw[9];
              lamps_nxt.standby_lamp = item.standby_on || cw[9];
            end
            crcf_pkg::CH_OUT14:    out_ch_nxt[4] = cw;
            default: ;
          endcase
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r    <= 16'd0;
      low_r    <= 16'd0;
      ret_r    <= 16'd0;
      pc_r     <= 16'd0;
      eb_r     <= 3'd0;
      fb_r     <= 5'd0;
      feb_r    <= 3'd0;
      byte0_r  <= 8'd0;
      byte1_r  <= 8'd0;
      out_ch_r <= '{default: 15'd0};
      alarm_r  <= 1'b0;
      lamps_r  <= crcf_pkg::LAMP_RESET;
    end else begin
      acc_r    <= acc_nxt;
      low_r    <= low_nxt;
      ret_r    <= ret_nxt;
      pc_r     <= pc_nxt;
      eb_r     <= eb_nxt;
      fb_r     <= fb_nxt;
      feb_r    <= feb_nxt;
      byte0_r  <= byte0_nxt;
      byte1_r  <= byte1_nxt;
      out_ch_r <= out_ch_nxt;
      alarm_r  <= alarm_nxt;
      lamps_r  <= lamps_nxt;
    end
  end

  assign lamps = lamps_nxt;

endmodule
`default_nettype wire
